[hw/rtl/ntaf_pkg.sv]
// ----------------------------------------------------------------------------
// ntaf_pkg
// Shared types, constants and helpers for the number to ascii formatter.
// ----------------------------------------------------------------------------
package ntaf_pkg;

  // field widths
  localparam int KindW   = 3;
  localparam int ValueW  = 32;
  localparam int CharW   = 7;
  localparam int DigitN  = 10;              // decimal digits of a 32-bit value
  localparam int DataW   = 4 * DigitN;      // one nibble per digit
  localparam int IdxW    = 4;               // digit index 0..9
  localparam int ConvSteps = ValueW;        // one shift step per value bit
  localparam int StepW   = $clog2(ConvSteps);
  localparam int QDepth  = 2;

  // ascii codes
  localparam logic [CharW-1:0] CH_ZERO    = 7'h30;
  localparam logic [CharW-1:0] CH_ONE     = 7'h31;
  localparam logic [CharW-1:0] CH_UPPER_A = 7'h41;
  localparam logic [CharW-1:0] CH_X       = 7'h78;
  localparam logic [CharW-1:0] CH_B       = 7'h62;
  localparam logic [CharW-1:0] CH_COMMA   = 7'h2C;

  // digit positions that get a comma after them in grouped decimal
  localparam logic [IdxW-1:0] GRP_MIL_IDX = 4'd6;
  localparam logic [IdxW-1:0] GRP_THO_IDX = 4'd3;

  typedef enum logic [KindW-1:0] {
    KIND_DEC   = 3'd0,
    KIND_GRP   = 3'd1,
    KIND_HEX8  = 3'd2,
    KIND_HEX16 = 3'd3,
    KIND_HEX32 = 3'd4,
    KIND_BIN8  = 3'd5
  } kind_t;

  // one formatting job handed from the front to the back
  typedef struct packed {
    kind_t             kind;
    logic [IdxW-1:0]   top;    // index of the first digit to print
    logic [DataW-1:0]  data;   // bcd digits, hex nibbles or binary bits
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CONV,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_PFX0,
    B_PFX1,
    B_DIGIT,
    B_COMMA
  } back_state_t;

  // nibble to upper case hex / decimal digit character
  function automatic logic [CharW-1:0] digit_char(input logic [3:0] d);
    logic [CharW-1:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {3'b000, d};
    end else begin
      c = CH_UPPER_A + {3'b000, d} - 7'd10;
    end
    return c;
  endfunction

endpackage

[hw/rtl/ntaf_in_if.sv]
// ----------------------------------------------------------------------------
// ntaf_in_if
// Input channel: one number and its format kind per item.
// ----------------------------------------------------------------------------
interface ntaf_in_if;
  logic                          valid;
  logic                          ready;
  logic [ntaf_pkg::KindW-1:0]    kind;
  logic [ntaf_pkg::ValueW-1:0]   value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

[hw/rtl/ntaf_out_if.sv]
// ----------------------------------------------------------------------------
// ntaf_out_if
// Output channel: one ascii character per item, with a last-of-run flag.
// ----------------------------------------------------------------------------
interface ntaf_out_if;
  logic                          valid;
  logic                          ready;
  logic [ntaf_pkg::CharW-1:0]    character;
  logic                          last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

[hw/rtl/ntaf_front.sv]
// ----------------------------------------------------------------------------
// ntaf_front
// Accepts numbers, converts decimal kinds to bcd by shift-and-add-3 and
// builds a job with the digits and the first digit index.
// ----------------------------------------------------------------------------
module ntaf_front (
  input  logic            clk,
  input  logic            rst,
  ntaf_in_if.sink         number,
  output ntaf_pkg::job_t  job,
  output logic            job_valid,
  input  logic            job_ready
);
  import ntaf_pkg::*;

  localparam int ShW = DataW + ValueW;

  front_state_t          state, state_next;
  logic [ShW-1:0]        shreg;
  logic [ShW-1:0]        adj;
  kind_t                 kind;
  logic [StepW-1:0]      steps;
  logic                  accept;
  logic [IdxW-1:0]       top_dec;

  assign number.ready = (state == F_IDLE);
  assign accept       = number.valid && number.ready;

  // add 3 to every bcd digit of 5 or more before the shift
  always_comb begin
    adj = shreg;
    for (int i = 0; i < DigitN; i++) begin
      if (shreg[ValueW + 4*i +: 4] >= 4'd5) begin
        adj[ValueW + 4*i +: 4] = shreg[ValueW + 4*i +: 4] + 4'd3;
      end
    end
  end

  // highest nonzero digit, zero prints one digit
  always_comb begin
    top_dec = '0;
    for (int i = 0; i < DigitN; i++) begin
      if (shreg[ValueW + 4*i +: 4] != 4'd0) begin
        top_dec = IdxW'(i);
      end
    end
  end

  // job out
  always_comb begin
    job.kind = kind;
    job.data = shreg[ShW-1:ValueW];
    case (kind)
      KIND_DEC, KIND_GRP: job.top = top_dec;
      KIND_HEX8:          job.top = 4'd1;
      KIND_HEX16:         job.top = 4'd3;
      KIND_HEX32:         job.top = 4'd7;
      KIND_BIN8:          job.top = 4'd7;
      default:            job.top = '0;
    endcase
  end

  assign job_valid = (state == F_PUSH);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: begin
        if (accept) begin
          case (kind_t'(number.kind))
            KIND_DEC, KIND_GRP:                   state_next = F_CONV;
            KIND_HEX8, KIND_HEX16, KIND_HEX32,
            KIND_BIN8:                            state_next = F_PUSH;
            default:                              state_next = F_IDLE;
          endcase
        end
      end
      F_CONV: begin
        if (steps == '0) begin
          state_next = F_PUSH;
        end
      end
      F_PUSH: begin
        if (job_ready) begin
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  // datapath: load, then shift one value bit into the bcd digits per cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      kind  <= kind_t'(number.kind);
      steps <= StepW'(ConvSteps - 1);
      case (kind_t'(number.kind))
        KIND_HEX8:  shreg <= {32'd0, number.value[7:0], {ValueW{1'b0}}};
        KIND_HEX16: shreg <= {24'd0, number.value[15:0], {ValueW{1'b0}}};
        KIND_HEX32: shreg <= {8'd0, number.value, {ValueW{1'b0}}};
        KIND_BIN8:  shreg <= {32'd0, number.value[7:0], {ValueW{1'b0}}};
        default:    shreg <= {{DataW{1'b0}}, number.value};
      endcase
    end else if (state == F_CONV) begin
      shreg <= {adj[ShW-2:0], 1'b0};
      steps <= steps - 1'b1;
    end
  end

endmodule

[hw/rtl/ntaf_queue.sv]
// ----------------------------------------------------------------------------
// ntaf_queue
// Two-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
module ntaf_queue (
  input  logic               clk,
  input  logic               rst,
  input  ntaf_pkg::job_t     wr_data,
  input  logic               push,
  input  logic               pop,
  output ntaf_pkg::job_t     rd_data,
  output ntaf_pkg::q_stat_t  stat
);
  import ntaf_pkg::*;

  localparam int PtrW = $clog2(QDepth);
  localparam int CntW = $clog2(QDepth + 1);

  job_t              mem [QDepth];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CntW-1:0]   count;

  assign rd_data    = mem[rd_ptr];
  assign stat.full  = (count == CntW'(QDepth));
  assign stat.empty = (count == '0);

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(QDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[hw/rtl/ntaf_back.sv]
// ----------------------------------------------------------------------------
// ntaf_back
// Takes jobs from the queue and sends prefix, digits and commas one
// character per cycle, when text is ready, through an output register.
// ----------------------------------------------------------------------------
module ntaf_back (
  input  logic               clk,
  input  logic               rst,
  input  ntaf_pkg::job_t     job,
  input  ntaf_pkg::q_stat_t  stat,
  output logic               pop,
  ntaf_out_if.source         text
);
  import ntaf_pkg::*;

  back_state_t         state, state_next;
  job_t                cur;
  logic [IdxW-1:0]     idx, idx_next;
  logic                advance;
  logic                emit;
  logic [CharW-1:0]    ch;
  logic                lst;
  logic                ovalid;
  logic [CharW-1:0]    ochar;
  logic                olast;
  logic [IdxW-1:0]     idx_dn;

  assign advance        = !ovalid || text.ready;
  assign idx_dn         = idx - 1'b1;
  assign text.valid     = ovalid;
  assign text.character = ochar;
  assign text.last      = olast;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and character selection
  always_comb begin
    state_next = state;
    idx_next   = idx;
    pop        = 1'b0;
    emit       = 1'b0;
    ch         = CH_ZERO;
    lst        = 1'b0;
    case (state)
      B_IDLE: begin
        if (!stat.empty) begin
          pop      = 1'b1;
          idx_next = job.top;
          case (job.kind)
            KIND_HEX8, KIND_HEX16, KIND_HEX32, KIND_BIN8: state_next = B_PFX0;
            default:                                      state_next = B_DIGIT;
          endcase
        end
      end
      B_PFX0: begin
        if (advance) begin
          emit       = 1'b1;
          ch         = CH_ZERO;
          state_next = B_PFX1;
        end
      end
      B_PFX1: begin
        if (advance) begin
          emit       = 1'b1;
          ch         = (cur.kind == KIND_BIN8) ? CH_B : CH_X;
          state_next = B_DIGIT;
        end
      end
      B_DIGIT: begin
        if (advance) begin
          emit = 1'b1;
          if (cur.kind == KIND_BIN8) begin
            ch = cur.data[idx[2:0]] ? CH_ONE : CH_ZERO;
          end else begin
            ch = digit_char(cur.data[{idx, 2'b00} +: 4]);
          end
          if (idx == '0) begin
            lst        = 1'b1;
            state_next = B_IDLE;
          end else begin
            idx_next = idx_dn;
            // comma after the millions and after the thousands
            if (cur.kind == KIND_GRP && (idx == GRP_MIL_IDX || idx == GRP_THO_IDX)) begin
              state_next = B_COMMA;
            end
          end
        end
      end
      B_COMMA: begin
        if (advance) begin
          emit       = 1'b1;
          ch         = CH_COMMA;
          state_next = B_DIGIT;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // job and digit index
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= job;
    end
    idx <= idx_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (emit) begin
      ovalid <= 1'b1;
    end else if (text.ready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      ochar <= ch;
      olast <= lst;
    end
  end

endmodule

[hw/rtl/number_to_ascii_formatter.sv]
// ----------------------------------------------------------------------------
// number_to_ascii_formatter
// Formats an unsigned 32-bit number as decimal, grouped decimal, hex or
// binary ascii text, one character per output item.
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake      payload
//  number    in    valid/ready    kind[2:0], value[31:0]
//  text      out   valid/ready    character[6:0], last
//
//  decimal kinds pass the front as accept, bcd shift steps and hand-off;
//  hex and binary go from accept straight to hand-off. The back loads the
//  job, then sends one character per cycle while text is ready, up to 12
//  characters per number. The bcd shift loop sets the decimal rate; a
//  two-entry job queue lets the front convert the next number while the
//  back still sends characters.
//  Synchronous active high reset empties the queue and the output register.
//  A stalled text channel holds the back; the front stalls once the queue
//  is full. Kinds 6 and 7 are accepted and give no characters.
//
module number_to_ascii_formatter (
  input  logic        clk,
  input  logic        rst,
  ntaf_in_if.sink     number,
  ntaf_out_if.source  text
);
  import ntaf_pkg::*;

  job_t     f_job;
  logic     f_valid;
  logic     q_push;
  logic     q_pop;
  job_t     q_job;
  q_stat_t  q_stat;

  assign q_push = f_valid && !q_stat.full;

  ntaf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .number    (number),
    .job       (f_job),
    .job_valid (f_valid),
    .job_ready (!q_stat.full)
  );

  ntaf_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_data (f_job),
    .push    (q_push),
    .pop     (q_pop),
    .rd_data (q_job),
    .stat    (q_stat)
  );

  ntaf_back u_back (
    .clk  (clk),
    .rst  (rst),
    .job  (q_job),
    .stat (q_stat),
    .pop  (q_pop),
    .text (text)
  );

  // queue is never read when empty
  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_stat.empty)
    else $error("job queue popped while empty");

  // queue cannot be full and empty together
  a_stat_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(q_stat.full && q_stat.empty))
    else $error("job queue full and empty at once");

  // a push into a queue with one free slot, without a pop, fills it
  a_fill: assert property (@(posedge clk) disable iff (rst)
    (q_push && !q_pop && !q_stat.empty) |=> q_stat.full)
    else $error("job queue count lost a push");

endmodule
